// ===== design/c8_pkg.sv =====
// Shared types, sizes and codes of the CHIP-8 instruction core.
// Used by the controller, the datapath, the top level and the port checker.
package c8_pkg;

   // storage sizes (all powers of two: wrap by truncation)
   localparam int MEM_DEPTH   = 4096;
   localparam int MEM_AW      = $clog2(MEM_DEPTH);
   localparam int DISP_WIDTH  = 64;
   localparam int COL_W       = $clog2(DISP_WIDTH);
   localparam int DISP_HEIGHT = 32;
   localparam int ROW_W       = $clog2(DISP_HEIGHT);
   localparam int STACK_DEPTH = 16;
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int REG_COUNT   = 16;

   localparam logic [11:0] PROG_START_RESET = 12'h200;
   localparam logic [11:0] FONT_BASE_RESET  = 12'h000;

   // item codes
   localparam logic [2:0] OP_STEP  = 3'd0;
   localparam logic [2:0] OP_TICK  = 3'd1;
   localparam logic [2:0] OP_KEY   = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_ROW   = 3'd5;

   // register indexes of the configuration port
   localparam logic REG_PROG_START = 1'b0;
   localparam logic REG_FONT_BASE  = 1'b1;

   // instruction fields
   localparam logic [11:0] NNN_CLS  = 12'h0E0;
   localparam logic [11:0] NNN_RET  = 12'h0EE;
   localparam logic [7:0]  KK_SKP   = 8'h9E;
   localparam logic [7:0]  KK_SKNP  = 8'hA1;
   localparam logic [7:0]  KK_GETDT = 8'h07;
   localparam logic [7:0]  KK_WKEY  = 8'h0A;
   localparam logic [7:0]  KK_SETDT = 8'h15;
   localparam logic [7:0]  KK_SETST = 8'h18;
   localparam logic [7:0]  KK_ADDI  = 8'h1E;
   localparam logic [7:0]  KK_FONT  = 8'h29;
   localparam logic [7:0]  KK_BCD   = 8'h33;
   localparam logic [7:0]  KK_STORE = 8'h55;
   localparam logic [7:0]  KK_LOAD  = 8'h65;
   localparam logic [3:0]  FLAG_REG = 4'hF;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_WAIT    = 3'd1,
      ST_HALT    = 3'd2,
      ST_INVALID = 3'd3,
      ST_STACK   = 3'd4
   } c8_status_type;

   // follow-on work after the execute cycle
   typedef enum logic [2:0] {
      SEQ_DONE,
      SEQ_FLAG,
      SEQ_DRAW,
      SEQ_BCD,
      SEQ_STORE,
      SEQ_LOAD
   } c8_seq_type;

   // datapath operations, one per controller state
   typedef enum logic [3:0] {
      U_IDLE,
      U_ITEM,
      U_FETCH_LO,
      U_DECODE,
      U_RD_Y,
      U_RD_0,
      U_EXEC,
      U_DRAW_RD,
      U_DRAW_WR,
      U_VF,
      U_BCD,
      U_ST_RD,
      U_ST_WR,
      U_LD_RD,
      U_LD_WR,
      U_FINISH
   } c8_uop_type;

   typedef struct packed {
      c8_uop_type uop;
      logic       load;
      logic       take;
   } c8_cmd_type;

   typedef struct packed {
      logic       fetch_go;
      c8_seq_type seq;
      logic       last;
   } c8_stat_type;

endpackage

// ===== design/c8_ctrl.sv =====
// Controller of the CHIP-8 core: one-hot sequencer over fetch, decode,
// execute and the memory walks. Depends on c8_pkg.
module c8_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  c8_pkg::c8_stat_type stat,
   output c8_pkg::c8_cmd_type  cmd
);
   import c8_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE     = 16'h0001,
      S_ITEM     = 16'h0002,
      S_FETCH_LO = 16'h0004,
      S_DECODE   = 16'h0008,
      S_RD_Y     = 16'h0010,
      S_RD_0     = 16'h0020,
      S_EXEC     = 16'h0040,
      S_DRAW_RD  = 16'h0080,
      S_DRAW_WR  = 16'h0100,
      S_VF       = 16'h0200,
      S_BCD      = 16'h0400,
      S_ST_RD    = 16'h0800,
      S_ST_WR    = 16'h1000,
      S_LD_RD    = 16'h2000,
      S_LD_WR    = 16'h4000,
      S_FINISH   = 16'h8000
   } c8_state_type;

   c8_state_type state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         take;

   // take the result into the output register once it is free
   assign take      = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd.uop  = U_IDLE;
      cmd.load = 1'b0;
      cmd.take = take;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = S_ITEM;
         end
         S_ITEM: begin
            cmd.uop  = U_ITEM;
            state_in = stat.fetch_go ? S_FETCH_LO : S_FINISH;
         end
         S_FETCH_LO: begin
            cmd.uop  = U_FETCH_LO;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.uop  = U_DECODE;
            state_in = S_RD_Y;
         end
         S_RD_Y: begin
            cmd.uop  = U_RD_Y;
            state_in = S_RD_0;
         end
         S_RD_0: begin
            cmd.uop  = U_RD_0;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.uop = U_EXEC;
            unique case (stat.seq)
               SEQ_FLAG:  state_in = S_VF;
               SEQ_DRAW:  state_in = S_DRAW_RD;
               SEQ_BCD:   state_in = S_BCD;
               SEQ_STORE: state_in = S_ST_RD;
               SEQ_LOAD:  state_in = S_LD_RD;
               default:   state_in = S_FINISH;
            endcase
         end
         S_DRAW_RD: begin
            cmd.uop  = U_DRAW_RD;
            state_in = S_DRAW_WR;
         end
         S_DRAW_WR: begin
            cmd.uop  = U_DRAW_WR;
            state_in = stat.last ? S_VF : S_DRAW_RD;
         end
         S_VF: begin
            cmd.uop  = U_VF;
            state_in = S_FINISH;
         end
         S_BCD: begin
            cmd.uop  = U_BCD;
            state_in = stat.last ? S_FINISH : S_BCD;
         end
         S_ST_RD: begin
            cmd.uop  = U_ST_RD;
            state_in = S_ST_WR;
         end
         S_ST_WR: begin
            cmd.uop  = U_ST_WR;
            state_in = stat.last ? S_FINISH : S_ST_RD;
         end
         S_LD_RD: begin
            cmd.uop  = U_LD_RD;
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            cmd.uop  = U_LD_WR;
            state_in = stat.last ? S_FINISH : S_LD_RD;
         end
         S_FINISH: begin
            cmd.uop = U_FINISH;
            if (take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold the result until the beat is taken
   assign rsp_valid_in = take ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/c8_dp.sv =====
// Datapath of the CHIP-8 core: memory, register file, display rows, stack,
// timers, keys and the result register. Depends on c8_pkg.
module c8_dp (
   input  logic                clock,
   input  logic                reset,
   input  c8_pkg::c8_cmd_type  cmd,
   output c8_pkg::c8_stat_type stat,
   input  logic [2:0]          req_opcode,
   input  logic [11:0]         req_mem_address,
   input  logic [7:0]          req_write_byte,
   input  logic [3:0]          req_key_number,
   input  logic                req_key_down,
   input  logic [7:0]          req_random_byte,
   input  logic [4:0]          req_row_select,
   input  logic                cfg_pc_we,
   input  logic [11:0]         cfg_pc_val,
   input  logic [11:0]         font_base,
   output logic [7:0]          rsp_read_data,
   output logic [63:0]         rsp_row_pixels,
   output logic [11:0]         rsp_pc_value,
   output logic [2:0]          rsp_status,
   output logic                rsp_sound_on,
   output logic                rsp_display_touched
);
   import c8_pkg::*;

   // storage arrays
   logic [7:0]            mem [MEM_DEPTH];
   logic [7:0]            rf [REG_COUNT];
   logic [DISP_WIDTH-1:0] disp [DISP_HEIGHT];
   logic [11:0]           stk [STACK_DEPTH];

   logic [7:0]             mem_q_ff;
   logic [7:0]             rf_q_ff;
   logic [REG_COUNT-1:0]   rf_vld_ff;
   logic [DISP_WIDTH-1:0]  disp_q_ff;
   logic [DISP_HEIGHT-1:0] disp_vld_ff;

   // architectural state
   logic [11:0]     pc_ff, pc_in;
   logic [11:0]     i_ff, i_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [7:0]      dt_ff, dt_in;
   logic [7:0]      st_ff, st_in;
   logic [15:0]     keys_ff, keys_in;
   logic            kwait_ff, kwait_in;
   logic [3:0]      ktgt_ff, ktgt_in;

   // item and instruction working registers
   logic [2:0]      op_ff;
   logic [11:0]     addr_ff;
   logic [7:0]      wb_ff;
   logic [3:0]      key_ff;
   logic            down_ff;
   logic [7:0]      rnd_ff;
   logic [4:0]      rsel_ff;
   logic [7:0]      hi_ff, hi_in;
   logic [7:0]      lo_ff, lo_in;
   logic [7:0]      vx_ff, vx_in;
   logic [7:0]      vy_ff, vy_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic [3:0]      lim_ff, lim_in;
   logic            flag_ff, flag_in;
   logic [3:0]      d0_ff, d0_in;
   logic [3:0]      d1_ff, d1_in;
   logic [3:0]      d2_ff, d2_in;
   logic            touched_ff, touched_in;
   c8_status_type   xstat_ff, xstat_in;

   // port controls
   logic              mem_we, mem_re;
   logic [MEM_AW-1:0] mem_wa, mem_ra;
   logic [7:0]        mem_wd;
   logic              rf_we, rf_re;
   logic [3:0]        rf_wa, rf_ra;
   logic [7:0]        rf_wd;
   logic              disp_we, disp_re, disp_clr;
   logic [ROW_W-1:0]  disp_wa, disp_ra;
   logic [DISP_WIDTH-1:0] disp_wd;
   logic              stk_we;
   logic [STK_AW-1:0] stk_wa;
   logic [11:0]       stk_wd;

   // decoded fields and helpers
   logic [11:0] nnn;
   logic [3:0]  xi, yi, ni;
   logic [11:0] nxt, skp;
   logic [11:0] i_off;
   logic [7:0]  row_sum;
   logic [STK_AW-1:0] sp_top;
   logic [8:0]  add9;
   logic [15:0] prod;
   logic [4:0]  q10;
   logic [1:0]  hund;
   logic [DISP_WIDTH-1:0] spr_mask;
   logic [COL_W-1:0] col;
   logic        key_hit;
   c8_seq_type  seq_sel;

   assign nnn     = {hi_ff[3:0], lo_ff};
   assign xi      = hi_ff[3:0];
   assign yi      = lo_ff[7:4];
   assign ni      = lo_ff[3:0];
   assign nxt     = pc_ff + 12'd2;
   assign skp     = pc_ff + 12'd4;
   assign i_off   = i_ff + {8'd0, cnt_ff};
   assign row_sum = vy_ff + {4'd0, cnt_ff};
   assign sp_top  = STK_AW'(sp_ff - SP_W'(1));
   assign add9    = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign key_hit = keys_ff[vx_ff[3:0]];
   // decimal digits via reciprocal multiply (exact below 320)
   assign prod    = {8'd0, vx_ff} * 16'd205;
   assign q10     = prod[15:11];
   assign hund    = (q10 >= 5'd20) ? 2'd2 : ((q10 >= 5'd10) ? 2'd1 : 2'd0);

   // sprite byte spread over the row, columns wrapping
   always_comb begin
      spr_mask = '0;
      col      = '0;
      for (int b = 0; b < 8; b++) begin
         col = vx_ff[COL_W-1:0] + COL_W'(b);
         if (mem_q_ff[7-b]) spr_mask[DISP_WIDTH-1-int'(col)] = 1'b1;
      end
   end

   assign stat.last     = (cnt_ff == lim_ff);
   assign stat.fetch_go = (op_ff == OP_STEP) && !kwait_ff;
   assign stat.seq      = seq_sel;

   // sequence decode of the fetched word
   always_comb begin
      seq_sel = SEQ_DONE;
      if ({hi_ff, lo_ff} != 16'd0) begin
         unique case (hi_ff[7:4])
            4'h8: if (ni == 4'h4 || ni == 4'h5 || ni == 4'h6 || ni == 4'h7 || ni == 4'hE)
                     seq_sel = SEQ_FLAG;
            4'hD: seq_sel = (ni == 4'd0) ? SEQ_FLAG : SEQ_DRAW;
            4'hF: begin
               if (lo_ff == KK_BCD)        seq_sel = SEQ_BCD;
               else if (lo_ff == KK_STORE) seq_sel = SEQ_STORE;
               else if (lo_ff == KK_LOAD)  seq_sel = SEQ_LOAD;
            end
            default: seq_sel = SEQ_DONE;
         endcase
      end
   end

   // operation of the current step
   always_comb begin
      pc_in = pc_ff; i_in = i_ff; sp_in = sp_ff; dt_in = dt_ff; st_in = st_ff;
      keys_in = keys_ff; kwait_in = kwait_ff; ktgt_in = ktgt_ff;
      hi_in = hi_ff; lo_in = lo_ff; vx_in = vx_ff; vy_in = vy_ff;
      cnt_in = cnt_ff; lim_in = lim_ff; flag_in = flag_ff;
      d0_in = d0_ff; d1_in = d1_ff; d2_in = d2_ff;
      touched_in = touched_ff; xstat_in = xstat_ff;
      mem_we = 1'b0; mem_re = 1'b0; mem_wa = '0; mem_ra = '0; mem_wd = '0;
      rf_we = 1'b0; rf_re = 1'b0; rf_wa = '0; rf_ra = '0; rf_wd = '0;
      disp_we = 1'b0; disp_re = 1'b0; disp_clr = 1'b0;
      disp_wa = '0; disp_ra = '0; disp_wd = '0;
      stk_we = 1'b0; stk_wa = sp_ff[STK_AW-1:0]; stk_wd = nxt;

      unique case (cmd.uop)
         U_ITEM: begin
            touched_in = 1'b0;
            xstat_in   = ST_WAIT;
            priority if (op_ff == OP_TICK) begin
               if (dt_ff != 8'd0) dt_in = dt_ff - 8'd1;
               if (st_ff != 8'd0) st_in = st_ff - 8'd1;
            end else if (op_ff == OP_KEY) begin
               if (down_ff) begin
                  keys_in[key_ff] = 1'b1;
                  if (kwait_ff) begin
                     rf_we    = 1'b1;
                     rf_wa    = ktgt_ff;
                     rf_wd    = {4'd0, key_ff};
                     kwait_in = 1'b0;
                  end
               end else begin
                  keys_in[key_ff] = 1'b0;
               end
            end else if (op_ff == OP_WRITE) begin
               mem_we = 1'b1;
               mem_wa = addr_ff[MEM_AW-1:0];
               mem_wd = wb_ff;
            end else if (op_ff == OP_READ) begin
               mem_re = 1'b1;
               mem_ra = addr_ff[MEM_AW-1:0];
            end else if (op_ff == OP_ROW) begin
               disp_re = 1'b1;
               disp_ra = rsel_ff[ROW_W-1:0];
            end else if (op_ff == OP_STEP) begin
               mem_re = !kwait_ff;
               mem_ra = pc_ff[MEM_AW-1:0];
            end else begin
               // unused item codes: nothing to do
            end
         end
         U_FETCH_LO: begin
            hi_in  = mem_q_ff;
            mem_re = 1'b1;
            mem_ra = MEM_AW'(pc_ff + 12'd1);
         end
         U_DECODE: begin
            lo_in = mem_q_ff;
            rf_re = 1'b1;
            rf_ra = hi_ff[3:0];
         end
         U_RD_Y: begin
            vx_in = rf_q_ff;
            rf_re = 1'b1;
            rf_ra = yi;
         end
         U_RD_0: begin
            vy_in = rf_q_ff;
            rf_re = 1'b1;
            rf_ra = 4'd0;
         end
         U_EXEC: begin
            xstat_in = ST_OK;
            cnt_in   = 4'd0;
            flag_in  = 1'b0;
            rf_wa    = xi;
            if ({hi_ff, lo_ff} == 16'd0) begin
               xstat_in = ST_HALT;
            end else begin
               unique case (hi_ff[7:4])
                  4'h0: begin
                     if (nnn == NNN_CLS) begin
                        disp_clr   = 1'b1;
                        touched_in = 1'b1;
                        pc_in      = nxt;
                     end else if (nnn == NNN_RET) begin
                        if (sp_ff == '0) xstat_in = ST_STACK;
                        else begin
                           sp_in = sp_ff - SP_W'(1);
                           pc_in = stk[sp_top];
                        end
                     end else begin
                        xstat_in = ST_INVALID;
                     end
                  end
                  4'h1: pc_in = nnn;
                  4'h2: begin
                     if (sp_ff >= SP_W'(STACK_DEPTH)) xstat_in = ST_STACK;
                     else begin
                        stk_we = 1'b1;
                        sp_in  = sp_ff + SP_W'(1);
                        pc_in  = nnn;
                     end
                  end
                  4'h3: pc_in = (vx_ff == lo_ff) ? skp : nxt;
                  4'h4: pc_in = (vx_ff != lo_ff) ? skp : nxt;
                  4'h5: pc_in = (vx_ff == vy_ff) ? skp : nxt;
                  4'h9: pc_in = (vx_ff != vy_ff) ? skp : nxt;
                  4'h6: begin
                     rf_we = 1'b1; rf_wd = lo_ff; pc_in = nxt;
                  end
                  4'h7: begin
                     rf_we = 1'b1; rf_wd = vx_ff + lo_ff; pc_in = nxt;
                  end
                  4'h8: begin
                     pc_in = nxt;
                     rf_we = 1'b1;
                     unique case (ni)
                        4'h0: rf_wd = vy_ff;
                        4'h1: rf_wd = vx_ff | vy_ff;
                        4'h2: rf_wd = vx_ff & vy_ff;
                        4'h3: rf_wd = vx_ff ^ vy_ff;
                        4'h4: begin rf_wd = add9[7:0]; flag_in = add9[8]; end
                        4'h5: begin rf_wd = vx_ff - vy_ff; flag_in = (vx_ff >= vy_ff); end
                        4'h6: begin rf_wd = {1'b0, vx_ff[7:1]}; flag_in = vx_ff[0]; end
                        4'h7: begin rf_wd = vy_ff - vx_ff; flag_in = (vy_ff >= vx_ff); end
                        4'hE: begin rf_wd = {vx_ff[6:0], 1'b0}; flag_in = vx_ff[7]; end
                        default: begin
                           rf_we = 1'b0; pc_in = pc_ff; xstat_in = ST_INVALID;
                        end
                     endcase
                  end
                  4'hA: begin i_in = nnn; pc_in = nxt; end
                  4'hB: pc_in = {4'd0, rf_q_ff} + nnn;
                  4'hC: begin
                     rf_we = 1'b1; rf_wd = rnd_ff & lo_ff; pc_in = nxt;
                  end
                  4'hD: begin
                     touched_in = 1'b1;
                     lim_in     = ni - 4'd1;
                     pc_in      = nxt;
                  end
                  4'hE: begin
                     if (lo_ff == KK_SKP)       pc_in = key_hit ? skp : nxt;
                     else if (lo_ff == KK_SKNP) pc_in = key_hit ? nxt : skp;
                     else                       xstat_in = ST_INVALID;
                  end
                  default: begin
                     pc_in = nxt;
                     priority if (lo_ff == KK_GETDT) begin
                        rf_we = 1'b1; rf_wd = dt_ff;
                     end else if (lo_ff == KK_WKEY) begin
                        kwait_in = 1'b1; ktgt_in = xi; xstat_in = ST_WAIT;
                     end else if (lo_ff == KK_SETDT) begin
                        dt_in = vx_ff;
                     end else if (lo_ff == KK_SETST) begin
                        st_in = vx_ff;
                     end else if (lo_ff == KK_ADDI) begin
                        i_in = i_ff + {4'd0, vx_ff};
                     end else if (lo_ff == KK_FONT) begin
                        i_in = font_base + {6'd0, vx_ff[3:0], 2'd0} + {8'd0, vx_ff[3:0]};
                     end else if (lo_ff == KK_BCD) begin
                        lim_in = 4'd2;
                        d0_in  = {2'd0, hund};
                        d1_in  = 4'(q10 - {hund, 3'd0} - {2'd0, hund, 1'b0});
                        d2_in  = 4'(vx_ff - ({3'd0, q10} * 8'd10));
                     end else if (lo_ff == KK_STORE || lo_ff == KK_LOAD) begin
                        lim_in = xi;
                     end else begin
                        pc_in = pc_ff; xstat_in = ST_INVALID;
                     end
                  end
               endcase
            end
         end
         U_DRAW_RD: begin
            mem_re  = 1'b1;
            mem_ra  = i_off[MEM_AW-1:0];
            disp_re = 1'b1;
            disp_ra = row_sum[ROW_W-1:0];
         end
         U_DRAW_WR: begin
            disp_we = 1'b1;
            disp_wa = row_sum[ROW_W-1:0];
            disp_wd = disp_q_ff ^ spr_mask;
            flag_in = flag_ff | (|(disp_q_ff & spr_mask));
            cnt_in  = cnt_ff + 4'd1;
         end
         U_VF: begin
            rf_we = 1'b1; rf_wa = FLAG_REG; rf_wd = {7'd0, flag_ff};
         end
         U_BCD: begin
            mem_we = 1'b1;
            mem_wa = i_off[MEM_AW-1:0];
            mem_wd = {4'd0, (cnt_ff == 4'd0) ? d0_ff : ((cnt_ff == 4'd1) ? d1_ff : d2_ff)};
            cnt_in = cnt_ff + 4'd1;
         end
         U_ST_RD: begin
            rf_re = 1'b1; rf_ra = cnt_ff;
         end
         U_ST_WR: begin
            mem_we = 1'b1; mem_wa = i_off[MEM_AW-1:0]; mem_wd = rf_q_ff;
            cnt_in = cnt_ff + 4'd1;
         end
         U_LD_RD: begin
            mem_re = 1'b1; mem_ra = i_off[MEM_AW-1:0];
         end
         U_LD_WR: begin
            rf_we = 1'b1; rf_wa = cnt_ff; rf_wd = mem_q_ff;
            cnt_in = cnt_ff + 4'd1;
         end
         default: begin
         end
      endcase

      // program_start write reloads the counter
      if (cfg_pc_we) pc_in = cfg_pc_val;
   end

   // main memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) mem_q_ff <= mem[mem_ra];
   end

   // register file, entries read as zero until written
   always_ff @(posedge clock) begin
      if (rf_we) rf[rf_wa] <= rf_wd;
      if (rf_re) rf_q_ff <= rf_vld_ff[rf_ra] ? rf[rf_ra] : 8'd0;
   end

   // display rows, a row reads as blank until drawn after a clear
   always_ff @(posedge clock) begin
      if (disp_we) disp[disp_wa] <= disp_wd;
      if (disp_re) disp_q_ff <= disp_vld_ff[disp_ra] ? disp[disp_ra] : '0;
   end

   // return stack
   always_ff @(posedge clock) begin
      if (stk_we) stk[stk_wa] <= stk_wd;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff   <= '0;
         disp_vld_ff <= '0;
         pc_ff       <= PROG_START_RESET;
         i_ff        <= 12'd0;
         sp_ff       <= '0;
         dt_ff       <= 8'd0;
         st_ff       <= 8'd0;
         keys_ff     <= 16'd0;
         kwait_ff    <= 1'b0;
         ktgt_ff     <= 4'd0;
      end else begin
         if (rf_we) rf_vld_ff[rf_wa] <= 1'b1;
         if (disp_clr)     disp_vld_ff <= '0;
         else if (disp_we) disp_vld_ff[disp_wa] <= 1'b1;
         pc_ff    <= pc_in;
         i_ff     <= i_in;
         sp_ff    <= sp_in;
         dt_ff    <= dt_in;
         st_ff    <= st_in;
         keys_ff  <= keys_in;
         kwait_ff <= kwait_in;
         ktgt_ff  <= ktgt_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         addr_ff <= req_mem_address;
         wb_ff   <= req_write_byte;
         key_ff  <= req_key_number;
         down_ff <= req_key_down;
         rnd_ff  <= req_random_byte;
         rsel_ff <= req_row_select;
      end
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      cnt_ff     <= cnt_in;
      lim_ff     <= lim_in;
      flag_ff    <= flag_in;
      d0_ff      <= d0_in;
      d1_ff      <= d1_in;
      d2_ff      <= d2_in;
      touched_ff <= touched_in;
      xstat_ff   <= xstat_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rsp_read_data       <= (op_ff == OP_READ) ? mem_q_ff : 8'd0;
         rsp_row_pixels      <= ((op_ff == OP_ROW) && ({1'b0, rsel_ff} < 6'(DISP_HEIGHT)))
                                ? disp_q_ff : '0;
         rsp_pc_value        <= pc_ff;
         rsp_status          <= (op_ff == OP_STEP) ? xstat_ff
                                : (kwait_ff ? ST_WAIT : ST_OK);
         rsp_sound_on        <= (st_ff != 8'd0);
         rsp_display_touched <= (op_ff == OP_STEP) && touched_ff;
      end
   end

endmodule

// ===== design/chip8_instruction_core_unit.sv =====
// Top level of the CHIP-8 instruction core: configuration registers and the
// controller/datapath pair. Depends on c8_pkg, c8_ctrl and c8_dp.
//
//   channel   direction  handshake           beat
//   req_*     in         req_valid/req_stall one item (step, tick, key, mem, row)
//   rsp_*     out        rsp_valid/rsp_stall one result per item
//   apb       in         psel/penable/pready program_start, font_base
//
// One item at a time. Tick, key, byte write, byte and row reads, and steps
// while waiting for a key go from the item state straight to the result. A
// step fetches two bytes, reads Vx, Vy and V0, executes, then runs any Dxyn,
// Fx33 or Fx55/Fx65 memory walk and VF write, one memory access per byte.
// Reset is synchronous; the output register lets a new item in while a
// result waits under rsp_stall.
module chip8_instruction_core_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [11:0] req_mem_address,
   input  logic [7:0]  req_write_byte,
   input  logic [3:0]  req_key_number,
   input  logic        req_key_down,
   input  logic [7:0]  req_random_byte,
   input  logic [4:0]  req_row_select,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [63:0] rsp_row_pixels,
   output logic [11:0] rsp_pc_value,
   output logic [2:0]  rsp_status,
   output logic        rsp_sound_on,
   output logic        rsp_display_touched,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import c8_pkg::*;

   logic [11:0] prog_start_ff, prog_start_in;
   logic [11:0] font_ff, font_in;
   logic        csr_wr;
   logic        csr_sel;
   c8_cmd_type  cmd;
   c8_stat_type stat;

   assign pready  = 1'b1;
   assign csr_sel = paddr[2];
   assign csr_wr  = psel && penable && pwrite && pready;

   // register writes
   always_comb begin
      prog_start_in = prog_start_ff;
      font_in       = font_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            REG_PROG_START: prog_start_in = pwdata[11:0];
            REG_FONT_BASE:  font_in       = pwdata[11:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_start_ff <= PROG_START_RESET;
         font_ff       <= FONT_BASE_RESET;
      end else begin
         prog_start_ff <= prog_start_in;
         font_ff       <= font_in;
      end
   end

   // register reads
   assign prdata = {20'd0, (csr_sel == REG_FONT_BASE) ? font_ff : prog_start_ff};

   c8_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   c8_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_opcode          (req_opcode),
      .req_mem_address     (req_mem_address),
      .req_write_byte      (req_write_byte),
      .req_key_number      (req_key_number),
      .req_key_down        (req_key_down),
      .req_random_byte     (req_random_byte),
      .req_row_select      (req_row_select),
      .cfg_pc_we           (csr_wr && (csr_sel == REG_PROG_START)),
      .cfg_pc_val          (pwdata[11:0]),
      .font_base           (font_ff),
      .rsp_read_data       (rsp_read_data),
      .rsp_row_pixels      (rsp_row_pixels),
      .rsp_pc_value        (rsp_pc_value),
      .rsp_status          (rsp_status),
      .rsp_sound_on        (rsp_sound_on),
      .rsp_display_touched (rsp_display_touched)
   );

endmodule

// ===== design/c8_chk.sv =====
// Port checker of the CHIP-8 instruction core, bound to the top level.
// Depends on c8_pkg and chip8_instruction_core_unit.
module c8_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_read_data,
   input logic [63:0] rsp_row_pixels,
   input logic [11:0] rsp_pc_value,
   input logic [2:0]  rsp_status
);
   import c8_pkg::*;

   // hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pc_value))
      else $error("stalled result changed");

   // no result straight out of reset
   a_rst_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");

   // a byte read and a row read never share one result
   a_one_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_data != 8'd0) |-> (rsp_row_pixels == '0))
      else $error("byte and row data in one result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= 3'(ST_STACK)))
      else $error("status code out of range");

endmodule

bind chip8_instruction_core_unit c8_chk u_c8_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_data  (rsp_read_data),
   .rsp_row_pixels (rsp_row_pixels),
   .rsp_pc_value   (rsp_pc_value),
   .rsp_status     (rsp_status)
);
